// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the verification checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ucs_pkg.sv =====
// ---------------------------------------------------------------------------
// ucs_pkg
// Types, class codes and decode helpers shared by the segmenter modules.
// ---------------------------------------------------------------------------
package ucs_pkg;

   localparam int unsigned BURST_MAX = 4;
   localparam int unsigned HOLD_MAX  = 3;

   localparam logic [2:0] CLASS_SPACE = 3'd0;
   localparam logic [2:0] CLASS_DIGIT = 3'd1;
   localparam logic [2:0] CLASS_LATIN = 3'd2;
   localparam logic [2:0] CLASS_HAN   = 3'd3;
   localparam logic [2:0] CLASS_PUNCT = 3'd4;
   localparam logic [2:0] CLASS_NONE  = 3'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [31:0] source_bytes;
      logic [2:0]  byte_count;
      logic [2:0]  char_class;
      logic        starts_run;
      logic        burst_last;
      logic        text_done;
   } rsp_type;

   // One decoded character before classification.
   typedef struct packed {
      logic [20:0] code_point;
      logic [31:0] source_bytes;
      logic [2:0]  byte_count;
   } item_type;

   // All characters caused by one input byte.
   typedef struct packed {
      item_type [BURST_MAX-1:0] items;
      logic [2:0]               count;
      logic                     text_end;
   } burst_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)             len = 3'd1;
      else if (b[7:5] == 3'b110)    len = 3'd2;
      else if (b[7:4] == 4'b1110)   len = 3'd3;
      else if (b[7:3] == 5'b11110)  len = 3'd4;
      else                          len = 3'd1;
      return len;
   endfunction

   function automatic item_type lone_item(input logic [7:0] b);
      item_type it;
      it.code_point   = {13'd0, b};
      it.source_bytes = {24'd0, b};
      it.byte_count   = 3'd1;
      return it;
   endfunction

   function automatic logic in_span(input logic [20:0] c, input logic [20:0] lo,
                                    input logic [20:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic [2:0] classify(input logic [20:0] c);
      logic [2:0] cls;
      if (c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D ||
          c == 21'h0C || c == 21'h0B || c == 21'h00A0 || c == 21'h3000)
         cls = CLASS_SPACE;
      else if (in_span(c, 21'h30, 21'h39) || in_span(c, 21'hFF10, 21'hFF19))
         cls = CLASS_DIGIT;
      else if (in_span(c, 21'h41, 21'h5A) || in_span(c, 21'h61, 21'h7A) ||
               in_span(c, 21'h00C0, 21'h024F) ||
               in_span(c, 21'hFF21, 21'hFF3A) || in_span(c, 21'hFF41, 21'hFF5A))
         cls = CLASS_LATIN;
      else if (in_span(c, 21'h4E00, 21'h9FFF) || in_span(c, 21'h3400, 21'h4DBF) ||
               in_span(c, 21'hF900, 21'hFAFF) || c == 21'h3007 ||
               in_span(c, 21'h20000, 21'h2A6DF) || in_span(c, 21'h2A700, 21'h2EBEF))
         cls = CLASS_HAN;
      else
         cls = CLASS_PUNCT;
      return cls;
   endfunction

endpackage

// ===== rtl/ucs_decode.sv =====
// ---------------------------------------------------------------------------
// ucs_decode
// Sequence state and the per-byte burst builder of the UTF-8 decoder.
// ---------------------------------------------------------------------------
module ucs_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ucs_pkg::req_type   req_data,
   output ucs_pkg::burst_type burst
);

   logic [7:0]  held_lead_ff, held_lead_in;
   logic [7:0]  fol_ff [ucs_pkg::HOLD_MAX];
   logic [7:0]  fol_in [ucs_pkg::HOLD_MAX];
   logic [2:0]  exp_len_ff, exp_len_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [20:0] part_ff, part_in;

   logic [7:0]  b;
   logic        text_end;
   logic [2:0]  len;
   logic        pending;
   logic        is_cont;
   logic        complete;
   logic        store;
   logic        flush;
   logic        start;
   logic        emit_b;
   logic [2:0]  pos;
   logic [1:0]  slot;
   logic [20:0] full_value;
   logic [31:0] src;

   always_comb begin
      b        = req_data.in_byte;
      text_end = req_data.end_of_text;
      len      = ucs_pkg::lead_length(b);
      pending  = exp_len_ff != 3'd0;
      is_cont  = b[7:6] == 2'b10;
      complete = pending && is_cont && (({1'b0, held_cnt_ff} + 3'd2) >= exp_len_ff);
      store    = pending && is_cont && !complete && !text_end;
      flush    = pending && !complete && !store;
      start    = !pending || !is_cont;
      emit_b   = (flush && is_cont) || (start && (len == 3'd1 || text_end));
      pos      = flush ? ({1'b0, held_cnt_ff} + 3'd1) : 3'd0;
      slot     = held_cnt_ff + 2'd1;
      full_value = {part_ff[14:0], b[5:0]};

      src = {24'd0, held_lead_ff};
      for (int k = 0; k < ucs_pkg::HOLD_MAX; k++) begin
         if (2'(k) < held_cnt_ff) src = src | ({24'd0, fol_ff[k]} << (8 * (k + 1)));
      end
      src = src | ({24'd0, b} << {slot, 3'b000});

      burst          = '0;
      burst.text_end = text_end;
      if (complete) begin
         burst.items[0].code_point   = full_value;
         burst.items[0].source_bytes = src;
         burst.items[0].byte_count   = {1'b0, held_cnt_ff} + 3'd2;
         burst.count                 = 3'd1;
      end
      if (flush) begin
         burst.items[0] = ucs_pkg::lone_item(held_lead_ff);
         for (int k = 0; k < ucs_pkg::HOLD_MAX; k++) begin
            if (2'(k) < held_cnt_ff) burst.items[k + 1] = ucs_pkg::lone_item(fol_ff[k]);
         end
         burst.count = pos;
      end
      if (emit_b) begin
         burst.items[pos[1:0]] = ucs_pkg::lone_item(b);
         burst.count           = pos + 3'd1;
      end

      // Next sequence state.
      held_lead_in = held_lead_ff;
      exp_len_in   = exp_len_ff;
      held_cnt_in  = held_cnt_ff;
      part_in      = part_ff;
      for (int k = 0; k < ucs_pkg::HOLD_MAX; k++) fol_in[k] = fol_ff[k];

      if (complete || flush) begin
         exp_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         part_in     = '0;
      end
      if (store) begin
         for (int k = 0; k < ucs_pkg::HOLD_MAX; k++) begin
            if (2'(k) == held_cnt_ff) fol_in[k] = b;
         end
         held_cnt_in = held_cnt_ff + 2'd1;
         part_in     = full_value;
      end
      if (start && len != 3'd1 && !text_end) begin
         held_lead_in = b;
         exp_len_in   = len;
         held_cnt_in  = 2'd0;
         case (len)
            3'd2:    part_in = {16'd0, b[4:0]};
            3'd3:    part_in = {17'd0, b[3:0]};
            default: part_in = {18'd0, b[2:0]};
         endcase
      end
      if (text_end) begin
         held_lead_in = 8'd0;
         exp_len_in   = 3'd0;
         held_cnt_in  = 2'd0;
         part_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff <= 8'd0;
         exp_len_ff   <= 3'd0;
         held_cnt_ff  <= 2'd0;
         part_ff      <= '0;
      end else if (accept) begin
         held_lead_ff <= held_lead_in;
         exp_len_ff   <= exp_len_in;
         held_cnt_ff  <= held_cnt_in;
         part_ff      <= part_in;
      end
   end

   // Held continuation bytes are only read after they were written.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < ucs_pkg::HOLD_MAX; k++) fol_ff[k] <= fol_in[k];
      end
   end

endmodule

// ===== rtl/ucs_emit.sv =====
// ---------------------------------------------------------------------------
// ucs_emit
// Burst register, classification and the result register.
// ---------------------------------------------------------------------------
module ucs_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               load_ok,
   input  ucs_pkg::burst_type burst,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ucs_pkg::rsp_type   rsp_data
);

   logic                bst_valid_ff, bst_valid_in;
   ucs_pkg::burst_type  bst_ff;
   logic [1:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ucs_pkg::rsp_type    rsp_ff, rsp_in;
   logic [2:0]          prev_ff, prev_in;

   ucs_pkg::item_type   cur;
   logic [2:0]          cls;
   logic                out_free;
   logic                move;
   logic                last_item;
   logic                take;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      move      = bst_valid_ff && out_free;
      last_item = {1'b0, idx_ff} == (bst_ff.count - 3'd1);
      load_ok   = !bst_valid_ff || (move && last_item);
      take      = req_valid && load_ok;
      cur       = bst_ff.items[idx_ff];
      cls       = ucs_pkg::classify(cur.code_point);

      bst_valid_in = bst_valid_ff;
      idx_in       = idx_ff;
      if (move) begin
         if (last_item) bst_valid_in = 1'b0;
         else           idx_in       = idx_ff + 2'd1;
      end
      if (take) begin
         bst_valid_in = burst.count != 3'd0;
         idx_in       = 2'd0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      prev_in      = prev_ff;
      if (move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.code_point   = cur.code_point;
         rsp_in.source_bytes = cur.source_bytes;
         rsp_in.byte_count   = cur.byte_count;
         rsp_in.char_class   = cls;
         rsp_in.starts_run   = prev_ff == ucs_pkg::CLASS_NONE || cls != prev_ff ||
                               cls == ucs_pkg::CLASS_PUNCT;
         rsp_in.burst_last   = last_item;
         rsp_in.text_done    = last_item && bst_ff.text_end;
         prev_in             = (last_item && bst_ff.text_end) ? ucs_pkg::CLASS_NONE : cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bst_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= ucs_pkg::CLASS_NONE;
      end else begin
         bst_valid_ff <= bst_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) bst_ff <= burst;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/utf8_char_class_segmenter_top.sv =====
// The characters of an accepted byte pass the burst register and then the result register.
// One byte per cycle while each byte yields at most one character and the result side does
// not stall; a byte that yields more holds the input until its last character moves on.
// Bytes that only extend a pending sequence yield nothing and leave the burst register empty.
// Reset (synchronous, active high) drops any pending sequence and any queued characters.
// ---------------------------------------------------------------------------
// utf8_char_class_segmenter_top
// Streaming UTF-8 decoder that tags every character with a class and a
// run-start flag and passes along the raw source bytes of each character.
// ---------------------------------------------------------------------------
module utf8_char_class_segmenter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ucs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ucs_pkg::rsp_type rsp_data
);

   // The decoder keeps the pending multi-byte sequence. For each accepted
   // transaction it builds, in one pass of logic, the whole list of
   // characters that the byte releases: a completed or single-byte character,
   // or on a malformed or truncated sequence the held bytes replayed one by
   // one followed by the new byte, unless that byte opens a new sequence.
   ucs_pkg::burst_type burst;
   logic               load_ok;
   logic               accept;

   // A new transaction is taken whenever the burst register is empty or
   // its last character leaves for the result register in this cycle.
   assign req_stall = !load_ok;
   assign accept    = req_valid && load_ok;

   ucs_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .burst    (burst)
   );

   // The emitter walks the burst one character per cycle unless a stalled
   // result holds it, classifies each, works out the run flag from the class
   // of the character before, and holds the result in a register so that a
   // stalled result does not block the next byte from entering.
   ucs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .load_ok   (load_ok),
      .burst     (burst),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/ucs_checker.sv =====
// ---------------------------------------------------------------------------
// ucs_checker
// Port-level assertions for the segmenter, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ucs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ucs_pkg::rsp_type rsp_data
);

   logic count_ok;
   logic is_punct;

   assign count_ok = rsp_data.byte_count != 3'd0 && rsp_data.byte_count <= 3'd4;
   assign is_punct = rsp_data.char_class == ucs_pkg::CLASS_PUNCT;

   // A stalled result transaction keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // Every character consumes one to four bytes.
   `ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, count_ok)

   // The end of a text is always the last character of its byte.
   `ASSERT_IMPLY(a_done_last, clock, reset, rsp_valid && rsp_data.text_done, rsp_data.burst_last)

   // Punctuation always opens a run of its own.
   `ASSERT_IMPLY(a_punct_run, clock, reset, rsp_valid && is_punct, rsp_data.starts_run)

endmodule

bind utf8_char_class_segmenter_top ucs_checker u_ucs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/utf8_char_class_segmenter_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_char_class_segmenter_top_tb
// Self-checking testbench for the streaming UTF-8 segmenter. A queue of text
// bytes feeds a clocked driver, and a shadow decoder predicts the characters
// that each accepted byte releases. A clocked monitor compares every
// character the block emits against the oldest prediction.
// ---------------------------------------------------------------------------
module utf8_char_class_segmenter_top_tb;

   // Clock and reset.
   logic    clock = 1'b0;
   logic    reset;

   // Block ports.
   logic             req_valid;
   logic             req_stall;
   ucs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ucs_pkg::rsp_type rsp_data;

   // Bytes still to be sent, and the characters the shadow decoder expects.
   ucs_pkg::req_type text_bytes [$];
   ucs_pkg::rsp_type expected_chars [$];
   // Characters released by the byte currently being decoded.
   ucs_pkg::rsp_type char_burst [$];
   // Scratch encoding of one character while the text is being built.
   logic [7:0] char_seq [$];

   // Set by the driver when a transaction is presented, cleared when taken.
   bit         in_flight;
   int         bytes_taken;
   int         error_count;

   // Shadow decoder state.
   logic [7:0]  dec_lead;
   logic [7:0]  dec_follow [3];
   logic [2:0]  dec_len;
   logic [1:0]  dec_held;
   logic [20:0] dec_value;
   logic [2:0]  dec_prev_class;

   utf8_char_class_segmenter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Shadow decoder
   // -----------------------------------------------------------------------

   // Sequence length announced by a lead byte. Anything that is not a
   // recognized lead, continuation bytes included, counts as a lone byte.
   function automatic logic [2:0] lead_bytes(input logic [7:0] b);
      logic [2:0] n;
      casez (b)
         8'b0???????: n = 3'd1;
         8'b110?????: n = 3'd2;
         8'b1110????: n = 3'd3;
         8'b11110???: n = 3'd4;
         default:     n = 3'd1;
      endcase
      return n;
   endfunction

   // Character class of a code point. Punctuation is the catch-all.
   function automatic logic [2:0] char_class_of(input logic [20:0] c);
      logic [2:0] cls;
      cls = ucs_pkg::CLASS_PUNCT;
      if (c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0B ||
          c == 21'h0C || c == 21'h0D || c == 21'hA0 || c == 21'h3000)
         cls = ucs_pkg::CLASS_SPACE;
      else if ((c >= 21'h30 && c <= 21'h39) || (c >= 21'hFF10 && c <= 21'hFF19))
         cls = ucs_pkg::CLASS_DIGIT;
      else if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
               (c >= 21'hC0 && c <= 21'h24F) ||
               (c >= 21'hFF21 && c <= 21'hFF3A) || (c >= 21'hFF41 && c <= 21'hFF5A))
         cls = ucs_pkg::CLASS_LATIN;
      else if ((c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
               (c >= 21'hF900 && c <= 21'hFAFF) || c == 21'h3007 ||
               (c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2A700 && c <= 21'h2EBEF))
         cls = ucs_pkg::CLASS_HAN;
      return cls;
   endfunction

   // Classify one character, work out its run flag and add it to the burst.
   // A burst never holds more than BURST_MAX characters.
   task automatic emit_char(input logic [20:0] cp, input logic [31:0] src,
                            input logic [2:0] cnt);
      ucs_pkg::rsp_type c;
      logic [2:0]       cls;
      if (char_burst.size() < ucs_pkg::BURST_MAX) begin
         cls = char_class_of(cp);
         c.code_point   = cp;
         c.source_bytes = src;
         c.byte_count   = cnt;
         c.char_class   = cls;
         c.starts_run   = (dec_prev_class == ucs_pkg::CLASS_NONE) ||
                          (cls != dec_prev_class) ||
                          (cls == ucs_pkg::CLASS_PUNCT);
         c.burst_last   = 1'b0;
         c.text_done    = 1'b0;
         dec_prev_class = cls;
         char_burst     = {char_burst, c};
      end
   endtask

   task automatic emit_lone(input logic [7:0] b);
      emit_char({13'd0, b}, {24'd0, b}, 3'd1);
   endtask

   task automatic clear_sequence();
      dec_len   = 3'd0;
      dec_held  = 2'd0;
      dec_value = 21'd0;
   endtask

   task automatic clear_decoder();
      dec_lead       = 8'd0;
      dec_follow     = '{8'd0, 8'd0, 8'd0};
      dec_prev_class = ucs_pkg::CLASS_NONE;
      clear_sequence();
   endtask

   // Give up on a pending sequence: its lead and each follower go out alone.
   task automatic flush_held();
      int k;
      emit_lone(dec_lead);
      for (k = 0; k < dec_held; k++)
         emit_lone(dec_follow[k]);
      clear_sequence();
   endtask

   // A byte seen with no sequence pending. A lead on the last byte of the
   // text cannot complete, so it goes out alone.
   task automatic start_byte(input logic [7:0] b, input logic last);
      logic [2:0] n;
      n = lead_bytes(b);
      if (n == 3'd1 || last) begin
         emit_lone(b);
      end else begin
         dec_lead = b;
         dec_len  = n;
         dec_held = 2'd0;
         case (n)
            3'd2:    dec_value = {16'd0, b[4:0]};
            3'd3:    dec_value = {17'd0, b[3:0]};
            default: dec_value = {18'd0, b[2:0]};
         endcase
      end
   endtask

   // Predict every character released by one accepted byte.
   task automatic decode_byte(input ucs_pkg::req_type r);
      logic [7:0]  b;
      logic [31:0] src;
      int          k;
      b = r.in_byte;
      char_burst.delete();
      if (dec_len == 3'd0) begin
         start_byte(b, r.end_of_text);
      end else if (b[7:6] == 2'b10) begin
         dec_value = {dec_value[14:0], b[5:0]};
         if ({1'b0, dec_held} + 3'd2 >= dec_len) begin
            // Sequence complete: gather the source bytes, first byte lowest.
            src = {24'd0, dec_lead};
            for (k = 0; k < dec_held; k++)
               src = src | ({24'd0, dec_follow[k]} << (8 * (k + 1)));
            src = src | ({24'd0, b} << (8 * (dec_held + 1)));
            emit_char(dec_value, src, {1'b0, dec_held} + 3'd2);
            clear_sequence();
         end else if (r.end_of_text) begin
            flush_held();
            emit_lone(b);
         end else begin
            dec_follow[dec_held] = b;
            dec_held             = dec_held + 2'd1;
         end
      end else begin
         // Malformed continuation: replay what was held, then treat the
         // offending byte as a possible new lead.
         flush_held();
         start_byte(b, r.end_of_text);
      end
      if (char_burst.size() != 0) begin
         char_burst[char_burst.size() - 1].burst_last = 1'b1;
         char_burst[char_burst.size() - 1].text_done  = r.end_of_text;
      end
      expected_chars = {expected_chars, char_burst};
      // The end of a text returns everything to its reset state.
      if (r.end_of_text)
         clear_decoder();
   endtask

   // -----------------------------------------------------------------------
   // Text construction
   // -----------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b, input logic last);
      ucs_pkg::req_type r;
      r.in_byte     = b;
      r.end_of_text = last;
      text_bytes    = {text_bytes, r};
   endtask

   task automatic append_seq(input logic [7:0] b);
      char_seq = {char_seq, b};
   endtask

   // Encode a code point into char_seq with the given length. A length
   // longer than needed gives an overlong form, which the block accepts.
   task automatic encode_char(input logic [20:0] cp, input int len);
      char_seq.delete();
      case (len)
         1: append_seq({1'b0, cp[6:0]});
         2: begin
            append_seq({3'b110, cp[10:6]});
            append_seq({2'b10, cp[5:0]});
         end
         3: begin
            append_seq({4'b1110, cp[15:12]});
            append_seq({2'b10, cp[11:6]});
            append_seq({2'b10, cp[5:0]});
         end
         default: begin
            append_seq({5'b11110, cp[20:18]});
            append_seq({2'b10, cp[17:12]});
            append_seq({2'b10, cp[11:6]});
            append_seq({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Code points on either side of each class boundary.
   function automatic logic [20:0] edge_point(input int idx);
      logic [20:0] c;
      case (idx)
         0:  c = 21'h2F;    1:  c = 21'h3A;    2:  c = 21'h40;    3:  c = 21'h5B;
         4:  c = 21'h60;    5:  c = 21'h7B;    6:  c = 21'h9F;    7:  c = 21'hA1;
         8:  c = 21'hBF;    9:  c = 21'h24F;   10: c = 21'h250;   11: c = 21'h2FFF;
         12: c = 21'h3006;  13: c = 21'h3008;  14: c = 21'h33FF;  15: c = 21'h4DBF;
         16: c = 21'h4DFF;  17: c = 21'h9FFF;  18: c = 21'hA000;  19: c = 21'hF8FF;
         20: c = 21'hFAFF;  21: c = 21'hFB00;  22: c = 21'hFF0F;  23: c = 21'hFF1A;
         24: c = 21'hFF20;  25: c = 21'hFF3B;  26: c = 21'hFF40;  27: c = 21'hFF5B;
         28: c = 21'h1FFFF; 29: c = 21'h2A6DF; 30: c = 21'h2A6E0; 31: c = 21'h2A6FF;
         32: c = 21'h2A700; 33: c = 21'h2EBEF; 34: c = 21'h2EBF0; default: c = 21'h1FFFFF;
      endcase
      return c;
   endfunction

   function automatic int min_length(input logic [20:0] cp);
      int n;
      if (cp < 21'h80)         n = 1;
      else if (cp < 21'h800)   n = 2;
      else if (cp < 21'h10000) n = 3;
      else                     n = 4;
      return n;
   endfunction

   // Pick a random character, biased toward each class, and encode it.
   task automatic pick_char();
      logic [20:0] cp;
      int          len;
      case ($urandom_range(11))
         0: begin
            case ($urandom_range(5))
               0: cp = 21'h20; 1: cp = 21'h09; 2: cp = 21'h0A;
               3: cp = 21'h0B; 4: cp = 21'h0C; default: cp = 21'h0D;
            endcase
         end
         1:  cp = 21'($urandom_range(21'h39, 21'h30));
         2:  cp = $urandom_range(1) ? 21'($urandom_range(21'h5A, 21'h41))
                                    : 21'($urandom_range(21'h7A, 21'h61));
         3:  cp = 21'($urandom_range(21'h7F));
         4:  cp = 21'($urandom_range(21'h24F, 21'hC0));
         5:  cp = 21'($urandom_range(21'h7FF));
         6: begin
            case ($urandom_range(2))
               0:       cp = 21'($urandom_range(21'h9FFF, 21'h4E00));
               1:       cp = 21'($urandom_range(21'h4DBF, 21'h3400));
               default: cp = 21'($urandom_range(21'hFAFF, 21'hF900));
            endcase
         end
         7: begin
            case ($urandom_range(5))
               0: cp = 21'h3000;
               1: cp = 21'h3007;
               2: cp = 21'hA0;
               3: cp = 21'($urandom_range(21'hFF19, 21'hFF10));
               4: cp = 21'($urandom_range(21'hFF3A, 21'hFF21));
               default: cp = 21'($urandom_range(21'hFF5A, 21'hFF41));
            endcase
         end
         8:  cp = 21'($urandom_range(21'hFFFF));
         9:  cp = $urandom_range(1) ? 21'($urandom_range(21'h2A6DF, 21'h20000))
                                    : 21'($urandom_range(21'h2EBEF, 21'h2A700));
         10: cp = 21'($urandom_range(21'h1FFFFF));
         default: cp = edge_point($urandom_range(35));
      endcase
      len = min_length(cp);
      // Now and then an overlong form.
      if (len < 4 && $urandom_range(19) == 0)
         len = $urandom_range(4, len + 1);
      encode_char(cp, len);
   endtask

   // One text of mostly well-formed characters. A few characters are broken
   // by dropping a byte, replacing a continuation or slipping in a stray
   // continuation, so that fallback paths are reached mid-text and at its end.
   task automatic build_text();
      int         nchars;
      int         c;
      int         i;
      int         roll;
      logic [7:0] junk;
      nchars = $urandom_range(12, 1);
      for (c = 0; c < nchars; c++) begin
         pick_char();
         roll = $urandom_range(99);
         if (roll < 6 && char_seq.size() > 1) begin
            char_seq.delete(char_seq.size() - 1);
         end else if (roll < 11 && char_seq.size() > 1) begin
            junk = 8'($urandom_range(255));
            if (junk[7:6] == 2'b10)
               junk[6] = 1'b1;
            char_seq[$urandom_range(char_seq.size() - 1, 1)] = junk;
         end else if (roll < 14) begin
            char_seq.push_front({2'b10, 6'($urandom_range(63))});
         end
         for (i = 0; i < char_seq.size(); i++)
            add_byte(char_seq[i], (c == nchars - 1) && (i == char_seq.size() - 1));
      end
   endtask

   // Raw noise: random bytes with text ends scattered through them.
   task automatic build_noise();
      int n;
      int i;
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++)
         add_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(3) == 0));
   endtask

   // -----------------------------------------------------------------------
   // Flow control
   // -----------------------------------------------------------------------

   // The run cycles through four pressure phases of 40 accepted bytes each:
   // free flow, a mostly idle sender, a mostly stalling receiver, and both
   // sides idling now and then.
   function automatic int send_idle_pct();
      int p;
      case ((bytes_taken / 40) % 4)
         1:       p = 62;
         3:       p = 17;
         default: p = 0;
      endcase
      return p;
   endfunction

   function automatic int recv_stall_pct();
      int p;
      case ((bytes_taken / 40) % 4)
         2:       p = 62;
         3:       p = 17;
         default: p = 0;
      endcase
      return p;
   endfunction

   // Driver, sampling side. A transaction is taken at a rising edge with
   // valid high and stall low; the prediction is made on that same payload.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data);
         bytes_taken++;
         in_flight = 1'b0;
      end
   end

   // Driver, launching side. Inputs move on the falling edge only. A payload
   // that has not been taken stays put, and valid is never withdrawn while a
   // transaction is outstanding.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!in_flight) begin
         if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
            req_data  <= text_bytes.pop_front();
            req_valid <= 1'b1;
            in_flight = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, also changed on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct());
   end

   // Monitor. Every character the block hands over is checked against the
   // oldest prediction; one with nothing waiting is a failure as well.
   always @(posedge clock) begin
      ucs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: unexpected character", $realtime);
               $display("   actual   cp=%h src=%h cnt=%0d cls=%0d run=%b last=%b done=%b",
                        rsp_data.code_point, rsp_data.source_bytes, rsp_data.byte_count,
                        rsp_data.char_class, rsp_data.starts_run, rsp_data.burst_last,
                        rsp_data.text_done);
            end
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.code_point !== want.code_point ||
                rsp_data.source_bytes !== want.source_bytes ||
                rsp_data.byte_count !== want.byte_count ||
                rsp_data.char_class !== want.char_class ||
                rsp_data.starts_run !== want.starts_run ||
                rsp_data.burst_last !== want.burst_last ||
                rsp_data.text_done !== want.text_done) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: mismatch", $realtime);
                  $display("   expected cp=%h src=%h cnt=%0d cls=%0d run=%b last=%b done=%b",
                           want.code_point, want.source_bytes, want.byte_count,
                           want.char_class, want.starts_run, want.burst_last,
                           want.text_done);
                  $display("   actual   cp=%h src=%h cnt=%0d cls=%0d run=%b last=%b done=%b",
                           rsp_data.code_point, rsp_data.source_bytes, rsp_data.byte_count,
                           rsp_data.char_class, rsp_data.starts_run, rsp_data.burst_last,
                           rsp_data.text_done);
               end
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus and end of run
   // -----------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      clear_decoder();

      // ASCII of every class: a Latin run, a digit, a space, punctuation.
      add_byte(8'h41, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h30, 1'b0);
      add_byte(8'h20, 1'b0);
      add_byte(8'h21, 1'b1);
      // Two-, three- and four-byte characters, the last one ending the text.
      add_byte(8'hC3, 1'b0);
      add_byte(8'hA9, 1'b0);
      add_byte(8'hE4, 1'b0);
      add_byte(8'hB8, 1'b0);
      add_byte(8'hAD, 1'b0);
      add_byte(8'hF0, 1'b0);
      add_byte(8'hA0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b1);
      // A lead followed by a byte that is not a continuation.
      add_byte(8'hC3, 1'b0);
      add_byte(8'h41, 1'b0);
      // A four-byte lead broken after two followers: the largest burst.
      add_byte(8'hF0, 1'b0);
      add_byte(8'hA0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h41, 1'b0);
      // A stray continuation and two bytes that can never lead.
      add_byte(8'h80, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hF8, 1'b0);
      // The text ends inside a three-byte sequence.
      add_byte(8'hE4, 1'b0);
      add_byte(8'hB8, 1'b1);
      // A lead byte that is itself the last byte of the text.
      add_byte(8'hC3, 1'b1);

      while (text_bytes.size() < 245) begin
         if ($urandom_range(9) == 0)
            build_noise();
         else
            build_text();
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Drain: all bytes taken and every predicted character seen, then a
      // further wait to catch anything extra the block might emit.
      while (text_bytes.size() != 0 || in_flight || expected_chars.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
